// ===== src/keyboard_scancode_to_ascii_unit_assert.svh =====
// Assertion macros used by the property checker (src/ksa_checker.sv) of the scan code translator.
// They are clocked by aclk and disabled while aresetn is low.
`ifndef KEYBOARD_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ksa_pkg.sv =====
`default_nettype none

package ksa_pkg;

    localparam int KEY_W  = 7;
    localparam int CHAR_W = 7;

    // Set-1 make codes of the modifier keys.
    localparam logic [KEY_W-1:0] SC_SHIFT_L   = 7'h2A;
    localparam logic [KEY_W-1:0] SC_SHIFT_R   = 7'h36;
    localparam logic [KEY_W-1:0] SC_CTRL_L    = 7'h1D;
    localparam logic [KEY_W-1:0] SC_ALT_L     = 7'h38;
    localparam logic [KEY_W-1:0] SC_CAPS_LOCK = 7'h3A;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'd90;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'd122;
    localparam logic [CHAR_W-1:0] CASE_BIT     = 7'h20;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } flags_t;

    // Character ROM: the lower half is the unshifted table, the upper half the
    // shifted one, so the address is {shift, key}.
    localparam logic [CHAR_W-1:0] CHAR_ROM [256] = '{
        // unshifted
        7'd0,   7'd0,   7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
        7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
        7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
        7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,   7'd97,  7'd115,
        7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
        7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
        7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,
        7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd55,
        7'd56,  7'd57,  7'd45,  7'd52,  7'd53,  7'd54,  7'd43,  7'd49,
        7'd50,  7'd51,  7'd48,  7'd46,  7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        // shifted
        7'd0,   7'd0,   7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
        7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,
        7'd81,  7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
        7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,   7'd65,  7'd83,
        7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
        7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,
        7'd66,  7'd78,  7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,
        7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd55,
        7'd56,  7'd57,  7'd45,  7'd52,  7'd53,  7'd54,  7'd43,  7'd49,
        7'd50,  7'd51,  7'd48,  7'd46,  7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
    };

endpackage

`default_nettype wire

// ===== src/keyboard_scancode_to_ascii_unit.sv =====
// A result is registered in the a stage at the edge that accepts its scan code and then
// in the m stage, which drives m_valid; an output stall can hold it in either stage.
// Throughput: one scan code per cycle unless the output stalls; the character ROM read and
// the modifier flag update both complete in the accept cycle, so consecutive codes
// never wait on each other. Reset (aresetn low, synchronous) clears the shift, ctrl, alt
// and caps lock flags and empties both pipeline stages.
`default_nettype none

module keyboard_scancode_to_ascii_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_scan_code,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ksa_pkg::CHAR_W-1:0]       m_character,
    output logic                             m_is_press,
    output logic                             m_shift_held,
    output logic                             m_ctrl_held,
    output logic                             m_alt_held,
    output logic                             m_caps_on
);

    logic                          s_accept;
    logic                          a_ready;
    logic                          a_advance;
    logic [ksa_pkg::KEY_W-1:0]     key;
    logic                          press;
    logic [ksa_pkg::CHAR_W-1:0]    a_char_fixed;
    logic                          is_letter;

    ksa_pkg::flags_t flags_reg, flags_next;
    logic            a_valid_reg, a_valid_next;
    logic            m_valid_reg, m_valid_next;

    logic [ksa_pkg::CHAR_W-1:0]    a_char_reg;
    logic                          a_press_reg;
    ksa_pkg::flags_t               a_flags_reg;
    logic [ksa_pkg::CHAR_W-1:0]    m_char_reg;
    logic                          m_press_reg;
    ksa_pkg::flags_t               m_flags_reg;

    assign key   = s_scan_code[6:0];
    assign press = ~s_scan_code[7];

    // Each stage takes new data when it is empty or its contents move on.
    assign a_ready   = ~m_valid_reg | m_ready;
    assign s_ready   = ~a_valid_reg | a_ready;
    assign s_accept  = s_valid & s_ready;
    assign a_advance = a_valid_reg & a_ready;

    always_comb begin
        flags_next = flags_reg;
        if (s_accept) begin
            unique case (key) inside
                ksa_pkg::SC_SHIFT_L, ksa_pkg::SC_SHIFT_R: flags_next.shift = press;
                ksa_pkg::SC_CTRL_L:  flags_next.ctrl = press;
                ksa_pkg::SC_ALT_L:   flags_next.alt  = press;
                ksa_pkg::SC_CAPS_LOCK: begin
                    if (press) begin
                        flags_next.caps = ~flags_reg.caps;
                    end
                end
                default: ;
            endcase
        end
    end

    assign a_valid_next = s_accept ? 1'b1 : (a_advance ? 1'b0 : a_valid_reg);
    assign m_valid_next = a_advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            flags_reg   <= flags_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Registered ROM read, addressed with the shift state this code leaves behind.
    // Modifier keys read zero, so the updated flag is safe to use.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_char_reg  <= ksa_pkg::CHAR_ROM[{flags_next.shift, key}];
            a_press_reg <= press;
            a_flags_reg <= flags_next;
        end
    end

    assign is_letter =
        ((a_char_reg >= ksa_pkg::CHAR_UPPER_A) && (a_char_reg <= ksa_pkg::CHAR_UPPER_Z)) ||
        ((a_char_reg >= ksa_pkg::CHAR_LOWER_A) && (a_char_reg <= ksa_pkg::CHAR_LOWER_Z));

    // Caps lock swaps letter case by flipping the ASCII case bit.
    assign a_char_fixed = (a_flags_reg.caps && is_letter) ? (a_char_reg ^ ksa_pkg::CASE_BIT)
                                                          : a_char_reg;

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            m_char_reg  <= a_char_fixed;
            m_press_reg <= a_press_reg;
            m_flags_reg <= a_flags_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_character  = m_char_reg;
    assign m_is_press   = m_press_reg;
    assign m_shift_held = m_flags_reg.shift;
    assign m_ctrl_held  = m_flags_reg.ctrl;
    assign m_alt_held   = m_flags_reg.alt;
    assign m_caps_on    = m_flags_reg.caps;

endmodule

`default_nettype wire

// ===== src/ksa_checker.sv =====
`default_nettype none
`include "keyboard_scancode_to_ascii_unit_assert.svh"

module ksa_props (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [ksa_pkg::CHAR_W-1:0]  m_character,
    input wire logic                        m_shift_held,
    input wire logic                        m_caps_on
);

    logic upper_out;
    logic lower_out;
    logic out_stall;
    logic case_flip;

    assign upper_out = m_valid && (m_character >= ksa_pkg::CHAR_UPPER_A) &&
                       (m_character <= ksa_pkg::CHAR_UPPER_Z);
    assign lower_out = m_valid && (m_character >= ksa_pkg::CHAR_LOWER_A) &&
                       (m_character <= ksa_pkg::CHAR_LOWER_Z);
    assign out_stall = m_valid && !m_ready;
    assign case_flip = m_shift_held != m_caps_on;

    // A stalled result keeps its character.
    `KSA_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(m_character), "held result moved")
    // Input back-pressure only appears when both stages are full and the output stalls.
    `KSA_ASSERT_NOW(a_no_idle_stall, !s_ready, out_stall, "input stalled while pipeline has room")
    // An upper-case letter requires exactly one of shift and caps lock.
    `KSA_ASSERT_NOW(a_upper_case, upper_out, case_flip, "upper-case letter without a case flip")
    // A lower-case letter requires both or neither of shift and caps lock.
    `KSA_ASSERT_NOW(a_lower_case, lower_out, !case_flip, "lower-case letter with a case flip")

endmodule

bind keyboard_scancode_to_ascii_unit ksa_props u_ksa_props (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_character  (m_character),
    .m_shift_held (m_shift_held),
    .m_caps_on    (m_caps_on)
);

`default_nettype wire

// ===== dv/ksa_checker.sv =====
`default_nettype none

module ksa_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire logic [7:0]                 s_scan_code,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire logic [ksa_pkg::CHAR_W-1:0] m_character,
    input  wire logic                       m_is_press,
    input  wire logic                       m_shift_held,
    input  wire logic                       m_ctrl_held,
    input  wire logic                       m_alt_held,
    input  wire logic                       m_caps_on,
    output int                              error_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS_MAPPED = 84;

    // Only the first 84 key codes carry a character; everything above maps to zero.
    localparam logic [ksa_pkg::CHAR_W-1:0] PLAIN_CHARS [KEYS_MAPPED] = '{
        0,   0,   49,  50,  51,  52,  53,  54,
        55,  56,  57,  48,  45,  61,  8,   9,
        113, 119, 101, 114, 116, 121, 117, 105,
        111, 112, 91,  93,  10,  0,   97,  115,
        100, 102, 103, 104, 106, 107, 108, 59,
        39,  96,  0,   92,  122, 120, 99,  118,
        98,  110, 109, 44,  46,  47,  0,   42,
        0,   32,  0,   0,   0,   0,   0,   0,
        0,   0,   0,   0,   0,   0,   0,   55,
        56,  57,  45,  52,  53,  54,  43,  49,
        50,  51,  48,  46
    };

    localparam logic [ksa_pkg::CHAR_W-1:0] SHIFTED_CHARS [KEYS_MAPPED] = '{
        0,   0,   33,  64,  35,  36,  37,  94,
        38,  42,  40,  41,  95,  43,  8,   9,
        81,  87,  69,  82,  84,  89,  85,  73,
        79,  80,  123, 125, 10,  0,   65,  83,
        68,  70,  71,  72,  74,  75,  76,  58,
        34,  126, 0,   124, 90,  88,  67,  86,
        66,  78,  77,  60,  62,  63,  0,   42,
        0,   32,  0,   0,   0,   0,   0,   0,
        0,   0,   0,   0,   0,   0,   0,   55,
        56,  57,  45,  52,  53,  54,  43,  49,
        50,  51,  48,  46
    };

    typedef struct packed {
        logic [ksa_pkg::CHAR_W-1:0] character;
        logic                       is_press;
        logic                       shift_held;
        logic                       ctrl_held;
        logic                       alt_held;
        logic                       caps_on;
    } key_result_t;

    ksa_pkg::flags_t held;
    key_result_t     translated_q [$];
    int              mismatch_total = 0;
    int              queued_total = 0;

    assign error_count = mismatch_total;
    assign pending     = queued_total;

    // Updates the modifier flags and returns the character seen after the update.
    function automatic key_result_t translate_scan_code(input logic [7:0] code);
        logic [ksa_pkg::KEY_W-1:0]  key;
        logic                       make;
        logic [ksa_pkg::CHAR_W-1:0] ch;
        key_result_t                res;
        key  = code[ksa_pkg::KEY_W-1:0];
        make = ~code[7];
        case (key)
            ksa_pkg::SC_SHIFT_L, ksa_pkg::SC_SHIFT_R: held.shift = make;
            ksa_pkg::SC_CTRL_L:                       held.ctrl  = make;
            ksa_pkg::SC_ALT_L:                        held.alt   = make;
            ksa_pkg::SC_CAPS_LOCK: begin
                if (make) begin
                    held.caps = ~held.caps;
                end
            end
            default: ;
        endcase
        if (int'(key) < KEYS_MAPPED) begin
            ch = held.shift ? SHIFTED_CHARS[key] : PLAIN_CHARS[key];
        end else begin
            ch = '0;
        end
        if (held.caps &&
            ((ch >= ksa_pkg::CHAR_LOWER_A && ch <= ksa_pkg::CHAR_LOWER_Z) ||
             (ch >= ksa_pkg::CHAR_UPPER_A && ch <= ksa_pkg::CHAR_UPPER_Z))) begin
            ch = ch ^ ksa_pkg::CASE_BIT;
        end
        res.character  = ch;
        res.is_press   = make;
        res.shift_held = held.shift;
        res.ctrl_held  = held.ctrl;
        res.alt_held   = held.alt;
        res.caps_on    = held.caps;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        key_result_t want;
        if (!aresetn) begin
            held = '0;
            translated_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                translated_q.push_back(translate_scan_code(s_scan_code));
            end
            if (m_valid && m_ready) begin
                if (translated_q.size() == 0) begin
                    $error("result transaction arrived with no scan code outstanding");
                    mismatch_total++;
                end else begin
                    want = translated_q.pop_front();
                    check_field("character", 8'(want.character), 8'(m_character));
                    check_field("is_press", 8'(want.is_press), 8'(m_is_press));
                    check_field("shift_held", 8'(want.shift_held), 8'(m_shift_held));
                    check_field("ctrl_held", 8'(want.ctrl_held), 8'(m_ctrl_held));
                    check_field("alt_held", 8'(want.alt_held), 8'(m_alt_held));
                    check_field("caps_on", 8'(want.caps_on), 8'(m_caps_on));
                end
            end
        end
        queued_total = translated_q.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [ksa_pkg::KEY_W-1:0] key_code_t;

    localparam logic [7:0] BREAK_FLAG    = 8'h80;
    localparam int         RANDOM_ITEMS  = 1800;
    localparam int         HOLD_CYCLES   = 250;
    localparam int         DRAIN_CYCLES  = 10;

    localparam key_code_t MODIFIERS [5] = '{
        ksa_pkg::SC_SHIFT_L, ksa_pkg::SC_SHIFT_R, ksa_pkg::SC_CTRL_L,
        ksa_pkg::SC_ALT_L, ksa_pkg::SC_CAPS_LOCK
    };

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [7:0]                 s_scan_code = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [ksa_pkg::CHAR_W-1:0] m_character;
    logic                       m_is_press;
    logic                       m_shift_held;
    logic                       m_ctrl_held;
    logic                       m_alt_held;
    logic                       m_caps_on;
    int                         error_count;
    int                         pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int codes_sent = 0;
    int hold_requests = 0;
    int hold_served = 0;

    keyboard_scancode_to_ascii_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_scan_code  (s_scan_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_character  (m_character),
        .m_is_press   (m_is_press),
        .m_shift_held (m_shift_held),
        .m_ctrl_held  (m_ctrl_held),
        .m_alt_held   (m_alt_held),
        .m_caps_on    (m_caps_on)
    );

    ksa_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_scan_code  (s_scan_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_character  (m_character),
        .m_is_press   (m_is_press),
        .m_shift_held (m_shift_held),
        .m_ctrl_held  (m_ctrl_held),
        .m_alt_held   (m_alt_held),
        .m_caps_on    (m_caps_on),
        .error_count  (error_count),
        .pending      (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_served) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_served++;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_code(input logic [7:0] code);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_scan_code <= code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        codes_sent++;
    endtask

    task automatic press_key(input key_code_t key);
        send_code({1'b0, key});
    endtask

    task automatic release_key(input key_code_t key);
        send_code({1'b0, key} | BREAK_FLAG);
    endtask

    // Mostly typing bursts, most of them under a modifier and the rest with none;
    // a quarter are raw noise, and some bursts never release their modifier.
    task automatic type_burst();
        int         kind;
        logic [2:0] mod_sel;
        int         n_keys;
        key_code_t  key;
        kind = $urandom_range(99);
        if (kind < 25) begin
            send_code(8'($urandom_range(255)));
        end else begin
            mod_sel = 3'($urandom_range(7));
            if (mod_sel < 5) begin
                press_key(MODIFIERS[mod_sel]);
                if (MODIFIERS[mod_sel] == ksa_pkg::SC_CAPS_LOCK) begin
                    release_key(ksa_pkg::SC_CAPS_LOCK);
                end
            end
            n_keys = $urandom_range(6, 1);
            repeat (n_keys) begin
                key = ($urandom_range(9) == 0) ? key_code_t'($urandom_range(127))
                                               : key_code_t'($urandom_range(83));
                press_key(key);
                if ($urandom_range(9) < 7) begin
                    release_key(key);
                end
            end
            if (mod_sel < 5 && MODIFIERS[mod_sel] != ksa_pkg::SC_CAPS_LOCK &&
                $urandom_range(9) != 0) begin
                release_key(MODIFIERS[mod_sel]);
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_codes,
                             input bit long_hold);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = codes_sent + n_codes;
        while (codes_sent < target) begin
            if (long_hold && codes_sent >= target - n_codes / 2) begin
                hold_requests++;
                long_hold = 1'b0;
            end
            type_burst();
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: letters with and without shift, caps lock with and without
        // shift, release codes, every modifier and the edges of the byte.
        send_code(8'h1E);
        press_key(ksa_pkg::SC_SHIFT_L);
        send_code(8'h1E);
        send_code(8'h02);
        release_key(ksa_pkg::SC_SHIFT_L);
        press_key(ksa_pkg::SC_CAPS_LOCK);
        release_key(ksa_pkg::SC_CAPS_LOCK);
        send_code(8'h10);
        press_key(ksa_pkg::SC_SHIFT_R);
        send_code(8'h10);
        send_code(8'h27);
        release_key(ksa_pkg::SC_SHIFT_R);
        press_key(ksa_pkg::SC_CTRL_L);
        press_key(ksa_pkg::SC_ALT_L);
        release_key(ksa_pkg::SC_CTRL_L);
        release_key(ksa_pkg::SC_ALT_L);
        press_key(ksa_pkg::SC_CAPS_LOCK);
        send_code(8'h00);
        send_code(8'hFF);
        send_code(8'h7F);
        send_code(8'h80);
        send_code(8'h54);
        send_code(8'h53);
        send_code(8'h9E);
        send_code(8'h39);

        run_phase(0, 0, RANDOM_ITEMS / 4, 1'b1);
        run_phase(69, 0, RANDOM_ITEMS / 4, 1'b0);
        run_phase(0, 69, RANDOM_ITEMS / 4, 1'b0);
        run_phase(16, 16, RANDOM_ITEMS / 4, 1'b0);
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== keyboard_scancode_to_ascii_unit.f =====
+incdir+src
src/ksa_pkg.sv
src/keyboard_scancode_to_ascii_unit.sv
src/ksa_checker.sv
dv/ksa_checker.sv
dv/tb.sv
